/* src/binary_image_block_packer_macros.svh */
// Assertion macros used by the tile packer top-level module.
`ifndef BINARY_IMAGE_BLOCK_PACKER_MACROS_SVH
`define BINARY_IMAGE_BLOCK_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tile packer same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BIBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile packer next-cycle check failed");

`endif

/* src/bibp_pkg.sv */
// Types and constants of the binary image tile packer.
package bibp_pkg;

    localparam logic [7:0] PIXEL_SET      = 8'd255;
    localparam logic [3:0] MAX_BLOCK_ROWS = 4'd8;
    localparam logic [3:0] MAX_BLOCK_COLS = 4'd8;
    localparam int         CFG_DATA_W     = 16;
    localparam int         OUT_DEPTH      = 3;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BLOCK_ROWS   = 2'd2,
        CFG_BLOCK_COLS   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic        first;
        logic        emit;
        logic        last;
        logic [5:0]  shift;
        logic [15:0] tile_row;
        logic [11:0] tile_col;
    } t_scan;

    typedef struct packed {
        logic [63:0] pattern;
        logic [15:0] tile_row;
        logic [11:0] tile_col;
        logic        last;
    } t_tile_result;

endpackage

/* src/bibp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module bibp_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bibp_scan.sv */
// Configuration registers and raster position counters of the tile packer.
module bibp_scan #(
    parameter int MAX_IMAGE_WIDTH = 4096,
    parameter int IDX_W           = $clog2(MAX_IMAGE_WIDTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_write,
    input  bibp_pkg::t_cfg_reg                 i_cfg_index,
    input  logic [bibp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_advance,
    output bibp_pkg::t_scan                    o_info,
    output logic [IDX_W-1:0]                   o_idx
);

    import bibp_pkg::*;

    localparam logic [16:0] MAX_W = 17'(MAX_IMAGE_WIDTH);

    logic [12:0]      r_image_width;
    logic [15:0]      r_image_height;
    logic [3:0]       r_block_rows;
    logic [3:0]       r_block_cols;
    logic [IDX_W-1:0] r_pix_col, n_pix_col;
    logic [15:0]      r_pix_row, n_pix_row;
    logic [2:0]       r_rwb, n_rwb;
    logic [2:0]       r_cwt, n_cwt;
    logic [IDX_W-1:0] r_tile_col, n_tile_col;
    logic [15:0]      r_tile_row, n_tile_row;

    logic [16:0]      w_ext;
    logic [16:0]      w_clamp;
    logic [IDX_W-1:0] w_last;
    logic [15:0]      h_last;
    logic [3:0]       rows_cl;
    logic [3:0]       cols_cl;
    logic [2:0]       rows_last;
    logic [2:0]       cols_last;
    logic [6:0]       pos;
    logic [6:0]       area_up;
    logic [6:0]       top_bit;
    logic             row_end;
    logic             col_last;
    logic             frame_row;
    logic             band_last;
    logic             row_last;
    logic [IDX_W+11:0] tile_col_ext;

    always_comb begin
        w_ext   = {4'b0, r_image_width};
        w_clamp = (r_image_width == 13'd0) ? 17'd1 : ((w_ext > MAX_W) ? MAX_W : w_ext);
        w_last  = IDX_W'(w_clamp - 17'd1);
        h_last  = (r_image_height == 16'd0) ? 16'd0 : r_image_height - 16'd1;
        rows_cl = (r_block_rows == 4'd0) ? 4'd1
                : ((r_block_rows > MAX_BLOCK_ROWS) ? MAX_BLOCK_ROWS : r_block_rows);
        cols_cl = (r_block_cols == 4'd0) ? 4'd1
                : ((r_block_cols > MAX_BLOCK_COLS) ? MAX_BLOCK_COLS : r_block_cols);
        rows_last = 3'(rows_cl - 4'd1);
        cols_last = 3'(cols_cl - 4'd1);

        pos     = 7'(r_rwb) * 7'(cols_cl) + 7'(r_cwt);
        area_up = 7'(rows_cl) * 7'(cols_cl) + 7'd7;
        top_bit = {area_up[6:3], 3'b000} - 7'd1;

        row_end   = r_pix_col >= w_last;
        col_last  = (r_cwt >= cols_last) || row_end;
        frame_row = r_pix_row >= h_last;
        band_last = r_rwb >= rows_last;
        row_last  = band_last || frame_row;

        tile_col_ext    = {12'b0, r_tile_col};
        o_info.first    = (r_rwb == 3'd0) && (r_cwt == 3'd0);
        o_info.emit     = col_last && row_last;
        o_info.last     = row_end && frame_row;
        o_info.shift    = 6'(top_bit - pos);
        o_info.tile_row = r_tile_row;
        o_info.tile_col = tile_col_ext[11:0];
        o_idx           = r_tile_col;

        n_pix_col  = r_pix_col;
        n_pix_row  = r_pix_row;
        n_rwb      = r_rwb;
        n_cwt      = r_cwt;
        n_tile_col = r_tile_col;
        n_tile_row = r_tile_row;
        if (row_end) begin
            n_pix_col  = '0;
            n_cwt      = '0;
            n_tile_col = '0;
            if (frame_row) begin
                n_pix_row  = '0;
                n_rwb      = '0;
                n_tile_row = '0;
            end else begin
                n_pix_row = r_pix_row + 16'd1;
                if (band_last) begin
                    n_rwb      = '0;
                    n_tile_row = r_tile_row + 16'd1;
                end else begin
                    n_rwb = r_rwb + 3'd1;
                end
            end
        end else begin
            n_pix_col = r_pix_col + IDX_W'(1);
            if (r_cwt >= cols_last) begin
                n_cwt      = '0;
                n_tile_col = r_tile_col + IDX_W'(1);
            end else begin
                n_cwt = r_cwt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 13'd256;
            r_image_height <= 16'd256;
            r_block_rows   <= 4'd8;
            r_block_cols   <= 4'd8;
            r_pix_col      <= '0;
            r_pix_row      <= '0;
            r_rwb          <= '0;
            r_cwt          <= '0;
            r_tile_col     <= '0;
            r_tile_row     <= '0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[15:0];
                CFG_BLOCK_ROWS:   r_block_rows   <= i_cfg_data[3:0];
                CFG_BLOCK_COLS:   r_block_cols   <= i_cfg_data[3:0];
            endcase
            r_pix_col  <= '0;
            r_pix_row  <= '0;
            r_rwb      <= '0;
            r_cwt      <= '0;
            r_tile_col <= '0;
            r_tile_row <= '0;
        end else if (i_advance) begin
            r_pix_col  <= n_pix_col;
            r_pix_row  <= n_pix_row;
            r_rwb      <= n_rwb;
            r_cwt      <= n_cwt;
            r_tile_col <= n_tile_col;
            r_tile_row <= n_tile_row;
        end
    end

endmodule

/* src/bibp_out_fifo.sv */
// Three-entry result queue that decouples the packer from the output handshake.
module bibp_out_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  bibp_pkg::t_tile_result i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output bibp_pkg::t_tile_result o_data,
    output logic [1:0]             o_count
);

    import bibp_pkg::*;

    t_tile_result r_mem [OUT_DEPTH];
    logic [1:0]   r_wr_ptr, n_wr_ptr;
    logic [1:0]   r_rd_ptr, n_rd_ptr;
    logic [1:0]   r_count, n_count;
    logic         pop;

    always_comb begin
        pop      = (r_count != 2'd0) && i_ready;
        n_wr_ptr = (r_wr_ptr == 2'(OUT_DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
        n_rd_ptr = (r_rd_ptr == 2'(OUT_DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
        n_count  = r_count + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* src/binary_image_block_packer.sv */
// A tile's last pixel passes through the stage-1 registers and then the result queue before the tile can leave.
// Throughput: one pixel per cycle, set by one accumulator read and one write per cycle.
// The input stalls only while the three-entry result queue cannot absorb another tile.
// Reset clears counters and queue and loads the default sizes; accumulators are not cleared.
// Each tile's accumulator is overwritten at its first pixel, so no clearing pass exists.
module binary_image_block_packer #(
    parameter int MAX_IMAGE_WIDTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pixel_valid,
    output logic                            o_pixel_ready,
    input  logic [7:0]                      i_pixel_value,
    output logic                            o_tile_valid,
    input  logic                            i_tile_ready,
    output logic [63:0]                     o_tile_pattern,
    output logic [15:0]                     o_tile_row_index,
    output logic [11:0]                     o_tile_col_index,
    output logic                            o_last_tile,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  bibp_pkg::t_cfg_reg              i_cfg_index,
    input  logic [bibp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import bibp_pkg::*;

    localparam int IDX_W = $clog2(MAX_IMAGE_WIDTH);

    t_scan            scan_info;
    logic [IDX_W-1:0] scan_idx;
    logic             accept;

    logic             r_s1_valid;
    t_scan            r_s1_info;
    logic             r_s1_bit;
    logic [IDX_W-1:0] r_s1_idx;

    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_idx;
    logic [63:0]      r_fwd_data;

    logic [63:0]      ram_rdata;
    logic [63:0]      base_word;
    logic [63:0]      n_word;
    logic             push;
    t_tile_result     push_data;
    t_tile_result     out_data;
    logic [1:0]       fifo_count;

    assign o_cfg_ready   = 1'b1;
    assign o_pixel_ready = (3'(fifo_count) + 3'(push)) <= 3'(OUT_DEPTH - 1);
    assign accept        = i_pixel_valid && o_pixel_ready;

    bibp_scan #(
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
        .IDX_W           (IDX_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (accept),
        .o_info      (scan_info),
        .o_idx       (scan_idx)
    );

    bibp_ram #(
        .WIDTH  (64),
        .DEPTH  (MAX_IMAGE_WIDTH),
        .ADDR_W (IDX_W)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (n_word),
        .i_re    (accept),
        .i_raddr (scan_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        base_word = (r_fwd_valid && (r_fwd_idx == r_s1_idx)) ? r_fwd_data : ram_rdata;
        n_word    = (r_s1_info.first ? 64'd0 : base_word)
                  | (64'(r_s1_bit) << r_s1_info.shift);
        push      = r_s1_valid && r_s1_info.emit;
        push_data.pattern  = n_word;
        push_data.tile_row = r_s1_info.tile_row;
        push_data.tile_col = r_s1_info.tile_col;
        push_data.last     = r_s1_info.last;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= scan_info;
            r_s1_bit  <= i_pixel_value == PIXEL_SET;
            r_s1_idx  <= scan_idx;
        end
        if (r_s1_valid) begin
            r_fwd_idx  <= r_s1_idx;
            r_fwd_data <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (r_s1_valid) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    bibp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (o_tile_valid),
        .i_ready (i_tile_ready),
        .o_data  (out_data),
        .o_count (fifo_count)
    );

    assign o_tile_pattern   = out_data.pattern;
    assign o_tile_row_index = out_data.tile_row;
    assign o_tile_col_index = out_data.tile_col;
    assign o_last_tile      = out_data.last;

`include "binary_image_block_packer_macros.svh"

    `BIBP_ASSERT_NOW(a_queue_no_overflow, i_clk, i_rst_n, push && !(o_tile_valid && i_tile_ready), fifo_count < 2'(OUT_DEPTH))
    `BIBP_ASSERT_NOW(a_last_tile_emits, i_clk, i_rst_n, r_s1_valid && r_s1_info.last, r_s1_info.emit)
    `BIBP_ASSERT_NEXT(a_accept_enters_stage, i_clk, i_rst_n, accept, r_s1_valid && (r_s1_idx == $past(scan_idx)))

endmodule

/* tb/binary_image_block_packer_tb.sv */
// Testbench for the binary image tile packer: a self-checking run against a tile predictor.
`timescale 1ns / 1ps

module binary_image_block_packer_tb;
    import bibp_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 65535;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 520;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } ready_mode_e;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_pixel_valid = 1'b0;
    logic                  o_pixel_ready;
    logic [7:0]            i_pixel_value = 8'd0;
    logic                  o_tile_valid;
    logic                  i_tile_ready  = 1'b0;
    logic [63:0]           o_tile_pattern;
    logic [15:0]           o_tile_row_index;
    logic [11:0]           o_tile_col_index;
    logic                  o_last_tile;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_reg              i_cfg_index   = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic [7:0]   pixels_to_send [$];
    t_tile_result pending_tiles [$];
    int           mismatch_count = 0;

    // Predictor copy of the registers and the raster position.
    logic [12:0]  size_width;
    logic [15:0]  size_height;
    logic [3:0]   size_rows;
    logic [3:0]   size_cols;
    logic [11:0]  pix_col;
    logic [15:0]  pix_row;
    logic [2:0]   band_row;
    logic [2:0]   tile_x;
    logic [11:0]  tile_col;
    logic [15:0]  tile_row;
    logic [63:0]  tile_acc [MAX_WIDTH];

    // Register values last written by the stimulus, used to size each frame.
    logic [CFG_DATA_W-1:0] frame_w_data = 16'd256;
    logic [CFG_DATA_W-1:0] frame_h_data = 16'd256;

    int          burst_left = 0;
    int          gap_left   = 0;
    int          ready_left = 0;
    ready_mode_e ready_mode = READY_ALWAYS;

    binary_image_block_packer #(
        .MAX_IMAGE_WIDTH(MAX_WIDTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pixel_valid    (i_pixel_valid),
        .o_pixel_ready    (o_pixel_ready),
        .i_pixel_value    (i_pixel_value),
        .o_tile_valid     (o_tile_valid),
        .i_tile_ready     (i_tile_ready),
        .o_tile_pattern   (o_tile_pattern),
        .o_tile_row_index (o_tile_row_index),
        .o_tile_col_index (o_tile_col_index),
        .o_last_tile      (o_last_tile),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int eff_size(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic restart_raster();
        pix_col  = '0;
        pix_row  = '0;
        band_row = '0;
        tile_x   = '0;
        tile_col = '0;
        tile_row = '0;
    endtask

    task automatic set_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  size_width  = data[12:0];
            CFG_IMAGE_HEIGHT: size_height = data[15:0];
            CFG_BLOCK_ROWS:   size_rows   = data[3:0];
            CFG_BLOCK_COLS:   size_cols   = data[3:0];
            default: ;
        endcase
        restart_raster();
    endtask

    task automatic pack_pixel(input logic [7:0] px);
        int           w, h, r, c, nbytes, pos, shift;
        logic         row_end, col_last, frame_row, row_last;
        logic [63:0]  bitv;
        t_tile_result res;
        w         = eff_size(int'(size_width), MAX_WIDTH);
        h         = eff_size(int'(size_height), MAX_HEIGHT);
        r         = eff_size(int'(size_rows), int'(MAX_BLOCK_ROWS));
        c         = eff_size(int'(size_cols), int'(MAX_BLOCK_COLS));
        nbytes    = (r * c + 7) / 8;
        pos       = int'(band_row) * c + int'(tile_x);
        shift     = 8 * nbytes - 1 - pos;
        bitv      = (px == PIXEL_SET) ? (64'd1 << shift) : 64'd0;
        row_end   = int'(pix_col) >= w - 1;
        col_last  = (int'(tile_x) >= c - 1) || row_end;
        frame_row = int'(pix_row) >= h - 1;
        row_last  = (int'(band_row) >= r - 1) || frame_row;

        if (band_row == 0 && tile_x == 0) begin
            tile_acc[tile_col] = bitv;
        end else begin
            tile_acc[tile_col] = tile_acc[tile_col] | bitv;
        end

        if (col_last && row_last) begin
            res.pattern  = tile_acc[tile_col];
            res.tile_row = tile_row;
            res.tile_col = tile_col;
            res.last     = row_end && frame_row;
            pending_tiles.push_back(res);
        end

        if (row_end) begin
            pix_col  = '0;
            tile_x   = '0;
            tile_col = '0;
            if (frame_row) begin
                pix_row  = '0;
                band_row = '0;
                tile_row = '0;
            end else begin
                pix_row++;
                if (int'(band_row) >= r - 1) begin
                    band_row = '0;
                    tile_row++;
                end else begin
                    band_row++;
                end
            end
        end else begin
            pix_col++;
            if (int'(tile_x) >= c - 1) begin
                tile_x = '0;
                tile_col++;
            end else begin
                tile_x++;
            end
        end
    endtask

    always @(posedge i_clk) begin : tile_monitor
        t_tile_result want;
        if (!i_rst_n) begin
            size_width  = 13'd256;
            size_height = 16'd256;
            size_rows   = 4'd8;
            size_cols   = 4'd8;
            restart_raster();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                set_reg(i_cfg_index, i_cfg_data);
            end
            if (i_pixel_valid && o_pixel_ready) begin
                pack_pixel(i_pixel_value);
            end
            if (o_tile_valid && i_tile_ready) begin
                if (pending_tiles.size() == 0) begin
                    flag_mismatch($sformatf("unexpected tile (%0d,%0d) pattern %h",
                        o_tile_row_index, o_tile_col_index, o_tile_pattern));
                end else begin
                    want = pending_tiles.pop_front();
                    if (o_tile_pattern !== want.pattern)
                        flag_mismatch($sformatf("tile (%0d,%0d) pattern %h, expected %h",
                            want.tile_row, want.tile_col, o_tile_pattern, want.pattern));
                    if (o_tile_row_index !== want.tile_row)
                        flag_mismatch($sformatf("tile row index %0d, expected %0d",
                            o_tile_row_index, want.tile_row));
                    if (o_tile_col_index !== want.tile_col)
                        flag_mismatch($sformatf("tile column index %0d, expected %0d",
                            o_tile_col_index, want.tile_col));
                    if (o_last_tile !== want.last)
                        flag_mismatch($sformatf("tile (%0d,%0d) last flag %b, expected %b",
                            want.tile_row, want.tile_col, o_last_tile, want.last));
                end
            end
        end
    end

    // A new pixel is offered only once the previous transfer has completed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pixel_valid <= 1'b0;
            i_tile_ready  <= 1'b0;
        end else begin
            if (!i_pixel_valid || o_pixel_ready) begin
                if (gap_left > 0 || pixels_to_send.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_pixel_valid <= 1'b0;
                end else begin
                    i_pixel_valid <= 1'b1;
                    i_pixel_value <= pixels_to_send.pop_front();
                    if (burst_left == 0) burst_left = $urandom_range(1, 48);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (ready_left == 0) begin
                ready_mode = ready_mode_e'($urandom_range(0, 2));
                ready_left = $urandom_range(20, 120);
            end
            ready_left--;
            case (ready_mode)
                READY_ALWAYS: i_tile_ready <= 1'b1;
                READY_RANDOM: i_tile_ready <= ($urandom_range(0, 1) == 1);
                default:      i_tile_ready <= (ready_left % 6 == 0);
            endcase
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, h, r, c, input logic [3:0] sel);
        if (sel[0]) begin
            write_reg(CFG_IMAGE_WIDTH, w);
            frame_w_data = w;
        end
        if (sel[1]) begin
            write_reg(CFG_IMAGE_HEIGHT, h);
            frame_h_data = h;
        end
        if (sel[2]) write_reg(CFG_BLOCK_ROWS, r);
        if (sel[3]) write_reg(CFG_BLOCK_COLS, c);
        if (sel != 4'd0) i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pixels_to_send.size() != 0 || i_pixel_valid || pending_tiles.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_pixels(input int n);
        @(negedge i_clk);
        repeat (n) begin
            if ($urandom_range(0, 1) == 1) pixels_to_send.push_back(PIXEL_SET);
            else pixels_to_send.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int               random_sent;
        int               fw, fh, n;
        logic [15:0]      w_data, h_data, r_data, c_data;
        logic [3:0]       sel;
        random_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Partial tile at the right edge, block columns left at the reset size.
        configure(16'd3, 16'd2, 16'd2, 16'd0, 4'b0111);
        @(negedge i_clk);
        pixels_to_send = '{8'd255, 8'd0, 8'd254, 8'd255, 8'd127, 8'd255};

        // Zero sizes act as one: every pixel is a whole image.
        wait_idle();
        configure(16'd0, 16'd0, 16'd0, 16'd0, 4'b1111);
        @(negedge i_clk);
        pixels_to_send = '{8'd255, 8'd0, 8'd1};

        // Bits above the register widths are dropped and tile sizes saturate.
        wait_idle();
        configure(16'hE002, 16'hFFFF, 16'hFFFF, 16'hFFF9, 4'b1111);
        queue_pixels(16);

        // Oversized width saturates: one tile per column along the first row.
        wait_idle();
        configure(16'h1FFF, 16'd1, 16'd3, 16'd1, 4'b1111);
        queue_pixels(64);

        // Exact maximum width, cut short by the next register write.
        wait_idle();
        configure(16'd4096, 16'd2, 16'd1, 16'd8, 4'b1111);
        queue_pixels(40);

        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_data = 16'd0;
                1:       w_data = 16'($urandom_range(25, 40));
                default: w_data = 16'($urandom_range(1, 24));
            endcase
            if ($urandom_range(0, 5) == 0) w_data[15:13] = 3'($urandom_range(1, 7));
            h_data = 16'($urandom_range(0, 10));
            r_data = 16'($urandom);
            c_data = 16'($urandom);
            if ($urandom_range(0, 2) != 0) begin
                r_data[15:4] = '0;
                c_data[15:4] = '0;
            end
            sel = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'b1111;
            wait_idle();
            configure(w_data, h_data, r_data, c_data, sel);
            fw = eff_size(int'(frame_w_data[12:0]), MAX_WIDTH);
            fh = eff_size(int'(frame_h_data), MAX_HEIGHT);
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, fw * fh);
            else n = fw * fh * $urandom_range(1, 2);
            if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
            queue_pixels(n);
            random_sent += n;
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("binary_image_block_packer test passed");
        end else begin
            $display("binary_image_block_packer test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("binary_image_block_packer test failed");
        $finish;
    end

endmodule
